// ===== rtl/rtss_pkg.sv =====
`timescale 1ns / 1ps

package rtss_pkg;

   localparam int RTSS_RECORDS = 8;

   localparam int ACCT_W   = 31;
   localparam int BAL_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int REC_W    = ACCT_W + 1 + BAL_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_SORT   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED    = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_SORTED    = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef struct packed {
      logic [ACCT_W-1:0]       account;
      logic                    kind;
      logic signed [BAL_W-1:0] balance;
   } record_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      record_type rec;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/rtss_ram.sv =====
`timescale 1ns / 1ps

module rtss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rtss_ctrl.sv =====
`timescale 1ns / 1ps

module rtss_ctrl
   import rtss_pkg::*;
#(
   parameter int RECORDS = RTSS_RECORDS,
   localparam int IDX_W = $clog2(RECORDS),
   localparam int CNT_W = $clog2(RECORDS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  cmd_type                 cmd,
   input  record_type              req_rec,
   output logic                    busy,
   output rsp_type                 rsp,
   output logic                    ram_we,
   output logic [IDX_W-1:0]        ram_waddr,
   output record_type              ram_wdata,
   output logic [IDX_W-1:0]        ram_raddr,
   input  record_type              ram_rdata
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_HOLD   = 7'b0000100,
      S_CMP    = 7'b0001000,
      S_WBI    = 7'b0010000,
      S_EMIT0  = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ACCT_W-1:0] key_ff, key_in;
   record_type        held_ff, held_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  last_idx;
   logic              swap;

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign last_idx = cnt_m1[IDX_W-1:0];
   assign swap     = $signed(held_ff.balance) > $signed(ram_rdata.balance);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      held_in   = held_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      idx_in    = idx_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = held_ff;
      ram_raddr = '0;
      rsp       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_LOAD: begin
                     rsp.valid = 1'b1;
                     rsp.last  = 1'b1;
                     if (count_ff == CNT_W'(RECORDS)) begin
                        rsp.status = ST_FULL;
                     end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_ff[IDX_W-1:0];
                        ram_wdata  = req_rec;
                        rsp.status = ST_STORED;
                        rsp.rec    = req_rec;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SEARCH: begin
                     key_in = req_rec.account;
                     if (count_ff == '0) begin
                        rsp.valid  = 1'b1;
                        rsp.last   = 1'b1;
                        rsp.status = ST_NOT_FOUND;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_SORT: begin
                     if (count_ff == '0) begin
                        rsp.valid  = 1'b1;
                        rsp.last   = 1'b1;
                        rsp.status = ST_EMPTY;
                     end else if (count_ff == CNT_W'(1)) begin
                        idx_in   = '0;
                        state_in = S_EMIT;
                     end else begin
                        i_in     = '0;
                        state_in = S_HOLD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // one entry compared per cycle, next read issued alongside
         S_SEARCH: begin
            if (ram_rdata.account == key_ff) begin
               rsp.valid  = 1'b1;
               rsp.last   = 1'b1;
               rsp.status = ST_FOUND;
               rsp.rec    = ram_rdata;
               state_in   = S_IDLE;
            end else if (idx_ff == last_idx) begin
               rsp.valid  = 1'b1;
               rsp.last   = 1'b1;
               rsp.status = ST_NOT_FOUND;
               state_in   = S_IDLE;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               ram_raddr = idx_ff + IDX_W'(1);
            end
         end

         // hold slot i, then walk j over the rest
         S_HOLD: begin
            held_in   = ram_rdata;
            j_in      = i_ff + IDX_W'(1);
            ram_raddr = i_ff + IDX_W'(1);
            state_in  = S_CMP;
         end

         S_CMP: begin
            if (swap) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = held_ff;
               held_in   = ram_rdata;
            end
            if (j_ff == last_idx) begin
               state_in = S_WBI;
            end else begin
               j_in      = j_ff + IDX_W'(1);
               ram_raddr = j_ff + IDX_W'(1);
            end
         end

         // write back slot i, start the next pass on a different slot
         S_WBI: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = held_ff;
            if ((i_ff + IDX_W'(1)) == last_idx) begin
               state_in = S_EMIT0;
            end else begin
               i_in      = i_ff + IDX_W'(1);
               ram_raddr = i_ff + IDX_W'(1);
               state_in  = S_HOLD;
            end
         end

         S_EMIT0: begin
            idx_in   = '0;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            rsp.valid  = 1'b1;
            rsp.status = ST_SORTED;
            rsp.rec    = ram_rdata;
            if (idx_ff == last_idx) begin
               rsp.last = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               ram_raddr = idx_ff + IDX_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      held_ff <= held_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      idx_ff  <= idx_in;
   end

endmodule

// ===== rtl/record_table_search_and_sort_top.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake                   Word
// ---------  ---------  --------------------------  ------------------------------------
// request    in         start high while busy low   command, account, type, balance
// response   out        rsp_strobe, one cycle       status, account, type, balance, last
//
// Load and unused commands finish in the accept cycle and busy stays low; a
// load's response word is registered and follows in the next cycle, while
// an unused command gives none. After the accept edge a search holds busy
// until slot k matches or all n records miss. A sort of n >= 2 records makes
// a pass for each slot i but the last (hold slot i, compare it with each later
// slot, write slot i back), then an emit read and n emit words; a sort of one
// record goes straight to the emit. The single read port of the record memory sets the pace.
// Reset (synchronous) empties the table; the memory itself is not cleared.
// The receiver cannot stall: each response word is valid for one cycle only.
module record_table_search_and_sort_top
   import rtss_pkg::*;
#(
   parameter int RECORDS = RTSS_RECORDS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [ACCT_W-1:0]       req_account_no,
   input  logic                    req_account_type,
   input  logic signed [BAL_W-1:0] req_balance,
   output logic                    rsp_strobe,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [ACCT_W-1:0]       rsp_found_account,
   output logic                    rsp_found_type,
   output logic signed [BAL_W-1:0] rsp_found_balance,
   output logic                    rsp_last
);

   localparam int IDX_W = $clog2(RECORDS);

   record_type        req_rec;
   rsp_type           rsp_in;
   rsp_type           rsp_ff;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   record_type        ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [REC_W-1:0]  ram_rdata;
   logic [REC_W-1:0]  ram_data_w;

   // pack the request word into a table record
   assign req_rec.account = req_account_no;
   assign req_rec.kind    = req_account_type;
   assign req_rec.balance = req_balance;

   rtss_ctrl #(
      .RECORDS (RECORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd_type'(req_command)),
      .req_rec   (req_rec),
      .busy      (busy),
      .rsp       (rsp_in),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (record_type'(ram_rdata))
   );

   // record store: one write port, one registered read port
   rtss_ram #(
      .WIDTH (REC_W),
      .DEPTH (RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (REC_W'(ram_wdata)),
      .rd_addr (ram_raddr),
      .rd_data (ram_data_w)
   );

   assign ram_rdata = ram_data_w;

   // response register: hold each word for exactly one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status <= rsp_in.status;
      rsp_ff.rec    <= rsp_in.rec;
      rsp_ff.last   <= rsp_in.last;
   end

   assign rsp_strobe        = rsp_ff.valid;
   assign rsp_status        = rsp_ff.status;
   assign rsp_found_account = rsp_ff.rec.account;
   assign rsp_found_type    = rsp_ff.rec.kind;
   assign rsp_found_balance = rsp_ff.rec.balance;
   assign rsp_last          = rsp_ff.last;

endmodule

// ===== sim/record_table_search_and_sort_top_tb.sv =====
`timescale 1ns / 1ps

module record_table_search_and_sort_top_tb;
   import rtss_pkg::*;

   localparam int TABLE_SLOTS = RTSS_RECORDS;

   // One response word as the table should produce it.
   typedef struct packed {
      status_type status;
      record_type rec;
      logic       last;
   } table_word_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CMD_W-1:0]        req_command;
   logic [ACCT_W-1:0]       req_account_no;
   logic                    req_account_type;
   logic signed [BAL_W-1:0] req_balance;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic [ACCT_W-1:0]       rsp_found_account;
   logic                    rsp_found_type;
   logic signed [BAL_W-1:0] rsp_found_balance;
   logic                    rsp_last;

   // Shadow copy of the record table, kept in step with every accepted word.
   record_type  shadow_table [TABLE_SLOTS];
   int unsigned shadow_count = 0;

   // Response words still owed by the block, oldest first.
   table_word_type pending_words [$];

   int mismatch_count = 0;
   bit sender_idles   = 1'b1;

   record_table_search_and_sort_top #(
      .RECORDS(TABLE_SLOTS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_account_no   (req_account_no),
      .req_account_type (req_account_type),
      .req_balance      (req_balance),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_found_account(rsp_found_account),
      .rsp_found_type   (rsp_found_type),
      .rsp_found_balance(rsp_found_balance),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // Queue one expected word.
   function automatic void owe_word(status_type status, record_type rec, logic last);
      table_word_type w;
      w.status = status;
      w.rec    = rec;
      w.last   = last;
      pending_words.push_back(w);
   endfunction

   // Apply one accepted command to the shadow table and queue the words it owes.
   function automatic void predict_table(cmd_type cmd, logic [ACCT_W-1:0] acct,
                                         logic kind, logic signed [BAL_W-1:0] bal);
      record_type rec;
      record_type swap_rec;
      bit         hit;
      rec.account = acct;
      rec.kind    = kind;
      rec.balance = bal;
      hit         = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            if (shadow_count >= TABLE_SLOTS) begin
               // Table full: drop the record, zero payload.
               owe_word(ST_FULL, '0, 1'b1);
            end else begin
               shadow_table[shadow_count] = rec;
               shadow_count++;
               owe_word(ST_STORED, rec, 1'b1);
            end
         end
         CMD_SEARCH: begin
            // First match wins, scanning upward from slot 0.
            for (int i = 0; i < shadow_count; i++) begin
               if (!hit && shadow_table[i].account == acct) begin
                  owe_word(ST_FOUND, shadow_table[i], 1'b1);
                  hit = 1'b1;
               end
            end
            if (!hit)
               owe_word(ST_NOT_FOUND, '0, 1'b1);
         end
         CMD_SORT: begin
            if (shadow_count == 0) begin
               owe_word(ST_EMPTY, '0, 1'b1);
            end else begin
               // Exchange sort on signed balance; the table keeps the new order.
               for (int i = 0; i < shadow_count; i++) begin
                  for (int j = i + 1; j < shadow_count; j++) begin
                     if ($signed(shadow_table[i].balance) >
                         $signed(shadow_table[j].balance)) begin
                        swap_rec        = shadow_table[i];
                        shadow_table[i] = shadow_table[j];
                        shadow_table[j] = swap_rec;
                     end
                  end
               end
               for (int i = 0; i < shadow_count; i++)
                  owe_word(ST_SORTED, shadow_table[i], (i + 1 == shadow_count));
            end
         end
         default: begin
            // Unused command: no word, table untouched.
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t ns", what, got, want, $time);
      mismatch_count++;
   endtask

   // Compare every strobed response word against the oldest expectation.
   always @(posedge clock) begin
      table_word_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word, status", 64'(rsp_status), '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_found_account !== want.rec.account)
               report_mismatch("account", 64'(rsp_found_account), 64'(want.rec.account));
            if (rsp_found_type !== want.rec.kind)
               report_mismatch("type", 64'(rsp_found_type), 64'(want.rec.kind));
            if (rsp_found_balance !== want.rec.balance)
               report_mismatch("balance", 64'(unsigned'(rsp_found_balance)),
                               64'(unsigned'(want.rec.balance)));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
   end

   // Present one command word and hold it until the block takes it.
   // Drive on the falling edge; the word is taken at a rising edge with busy low.
   task automatic send_word(cmd_type cmd, logic [ACCT_W-1:0] acct, logic kind,
                            logic signed [BAL_W-1:0] bal);
      int gap;
      gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap != 0) begin
         // Drop start for a random burst before this word.
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            = 1'b1;
      req_command      = cmd;
      req_account_no   = acct;
      req_account_type = kind;
      req_balance      = bal;
      do @(posedge clock); while (busy !== 1'b0);
      predict_table(cmd, acct, kind, bal);
   endtask

   // Lower start and hold off until every owed word has come back.
   task automatic drain_table_words();
      @(negedge clock);
      start = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Sort and search on a table that holds nothing yet.
   task automatic test_empty_table();
      send_word(CMD_SORT, '0, 1'b0, '0);
      send_word(CMD_SEARCH, '0, 1'b0, '0);
      send_word(CMD_SEARCH, '1, 1'b1, '1);
   endtask

   // The unused command code must leave no trace, whatever the payload.
   task automatic test_ignored_command();
      send_word(CMD_NONE, '1, 1'b1, '1);
      send_word(CMD_NONE, '0, 1'b0, '0);
      drain_table_words();
   endtask

   // Fill the table two records at a time, sorting after each pair so that
   // new records land at the end of an already sorted table. Covers the
   // balance extremes, equal balances and a repeated account number.
   task automatic test_load_and_sort();
      send_word(CMD_LOAD, 31'd0,          1'b0, 32'sh8000_0000);
      send_word(CMD_LOAD, 31'h7FFF_FFFF,  1'b1, 32'sh7FFF_FFFF);
      send_word(CMD_SORT, '0, 1'b0, '0);
      send_word(CMD_LOAD, 31'd5,          1'b1, 32'sd0);
      send_word(CMD_LOAD, 31'd5,          1'b0, -32'sd1);
      send_word(CMD_SORT, '1, 1'b1, '1);
      send_word(CMD_LOAD, 31'd100,        1'b0, 32'sd0);
      send_word(CMD_LOAD, 31'd200,        1'b1, 32'sd1);
      send_word(CMD_SORT, '0, 1'b0, '0);
      send_word(CMD_LOAD, ACCT_W'($urandom()), 1'b1, 32'sh7FFF_FFFF);
      send_word(CMD_LOAD, ACCT_W'($urandom()), 1'b0, $urandom());
      send_word(CMD_SORT, '0, 1'b0, '0);
   endtask

   // One more load than the table holds.
   task automatic test_full_table();
      send_word(CMD_LOAD, '1, 1'b1, '1);
   endtask

   // Hits at both account extremes, the repeated account, and a miss.
   task automatic test_search_cases();
      send_word(CMD_SEARCH, 31'd0,         1'b1, '1);
      send_word(CMD_SEARCH, 31'd5,         1'b0, '0);
      send_word(CMD_SEARCH, 31'h7FFF_FFFF, 1'b0, '0);
      send_word(CMD_SEARCH, 31'd12345,     1'b1, $urandom());
   endtask

   // Random mix weighted toward searches that hit, with sorts, misses,
   // loads into the full table and the odd unused code. Payload bits are
   // random throughout, unused fields included.
   task automatic test_random_traffic(int words);
      int pick;
      logic [ACCT_W-1:0] acct;
      logic kind;
      for (int n = 0; n < words; n++) begin
         pick = $urandom_range(0, 99);
         acct = ACCT_W'($urandom());
         kind = 1'($urandom_range(0, 1));
         if (pick < 40 && shadow_count != 0)
            acct = shadow_table[$urandom_range(0, shadow_count - 1)].account;
         if (pick < 60)
            send_word(CMD_SEARCH, acct, kind, $urandom());
         else if (pick < 80)
            send_word(CMD_SORT, acct, kind, $urandom());
         else if (pick < 95)
            send_word(CMD_LOAD, acct, kind, $urandom());
         else
            send_word(CMD_NONE, acct, kind, $urandom());
      end
   endtask

   initial begin
      // Every input known from time zero; hold reset, then release it on a falling edge.
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = CMD_NONE;
      req_account_no   = '0;
      req_account_type = 1'b0;
      req_balance      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_ignored_command();
      test_load_and_sort();
      test_full_table();
      test_search_cases();
      drain_table_words();

      test_random_traffic(100);
      drain_table_words();
      // Last stretch runs back to back with no idling.
      sender_idles = 1'b0;
      test_random_traffic(40);

      // Let the final sort finish.
      drain_table_words();
      repeat (80) @(posedge clock);
      if (pending_words.size() != 0)
         report_mismatch("words never returned", 64'(pending_words.size()), '0);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run of this stimulus.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
